>>> rtl/qvdb_pkg.sv
// Shared constants, command/status structs and helpers for the quantized
// vertex decoder with bounds tracking. No dependencies.
package qvdb_pkg;

   localparam int MAX_VERTS    = 4096;
   localparam int MIN_VERTS    = 3;
   localparam int IDX_W        = $clog2(MAX_VERTS);
   localparam int CNT_W        = 13;
   localparam int NORMAL_COUNT = 162;

   localparam int REQ_DATA_W = 224;
   localparam int RSP_DATA_W = 264;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // 0.07 as a Q0.24 fraction
   localparam logic [20:0] K_007 = 21'd1174405;
   localparam logic [31:0] RESIZE_RESET = 32'h0001_0000;

   // opcodes carried on req_tuser
   localparam logic [1:0] OPC_HEADER = 2'd0;
   localparam logic [1:0] OPC_VERTEX = 2'd1;
   localparam logic [1:0] OPC_FINISH = 2'd2;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_MODEL  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESIZE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VCOUNT = 8'd1;

   // datapath step codes, issued in this order for each axis
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_NONE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MA   = 4'd1; // byte * resize
   localparam logic [STEP_W-1:0] STEP_MH   = 4'd2; // upper part * scale
   localparam logic [STEP_W-1:0] STEP_ML   = 4'd3; // lower part * scale
   localparam logic [STEP_W-1:0] STEP_SUM  = 4'd4; // add translate, clamp
   localparam logic [STEP_W-1:0] STEP_MK   = 4'd5; // * 0.07
   localparam logic [STEP_W-1:0] STEP_RND  = 4'd6; // sign, round, saturate
   localparam logic [STEP_W-1:0] STEP_SQ   = 4'd7; // square
   localparam logic [STEP_W-1:0] STEP_ACC  = 4'd8; // accumulate length

   localparam int AXIS_W = 2;
   localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_POS   = 2'd1; // the one output axis not negated
   localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

   typedef struct packed {
      logic              load_hdr;
      logic              load_vtx;
      logic [STEP_W-1:0] step;
      logic [AXIS_W-1:0] axis;
      logic              emit_vtx;
      logic              emit_frame;
      logic              emit_model;
   } qvdb_cmd_type;

   typedef struct packed {
      logic out_free;
      logic frame_end;
   } qvdb_status_type;

   // output axis -> file axis: x takes file axis 1, y axis 2, z axis 0
   function automatic logic [AXIS_W-1:0] file_axis(input logic [AXIS_W-1:0] axis);
      logic [AXIS_W-1:0] fa;
      unique case (axis)
         2'd0:    fa = 2'd1;
         2'd1:    fa = 2'd2;
         default: fa = 2'd0;
      endcase
      return fa;
   endfunction

endpackage

>>> rtl/quantized_vertex_decode_bounds.sv
// Vertex item: accepted when idle; after 3 axes x 8 steps of the shared per-axis multiply
// chain, the update state loads the result beat. The next item is taken after that, or after
// the frame-bounds beat when one follows. A stalled result beat delays both.
// Header item: loaded on accept. Finish item: the model-bounds state loads the model-bounds beat.
// Reset (synchronous, active high) clears transform, bounds, vertex index and
// restores resize 1.0 and vertex_count 3; no clearing pass is needed.
module quantized_vertex_decode_bounds import qvdb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // scale x,y,z, offset x,y,z (32 each), packed x,y,z (8 each), normal_code (8)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pos_or_min x,y,z, corner_max x,y,z (32 each), radius_squared (63),
   // normal_out (8), normal_bad (1)
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   qvdb_cmd_type    cmd;
   qvdb_status_type status;

   assign csr_ready = 1'b1;

   qvdb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   qvdb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_wr     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/qvdb_datapath.sv
// Datapath of the vertex decoder: configuration registers, per-axis multiply
// chain, bounds registers and the result register. Uses qvdb_pkg.
module qvdb_datapath import qvdb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  qvdb_cmd_type          cmd,
   output qvdb_status_type       status,
   input  logic                  csr_wr,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic signed [57:0] C_LIM     = 58'sd1 <<< 40;
   localparam logic signed [63:0] RND_HALF  = 64'sd1 <<< 23;
   localparam logic signed [63:0] I32_MAX   = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN   = -64'sd2147483648;
   localparam logic signed [31:0] POS_MAX   = 32'sh7fff_ffff;
   localparam logic signed [31:0] POS_MIN   = 32'sh8000_0000;
   localparam logic        [62:0] RAD_MAX   = {63{1'b1}};

   // configuration
   logic [31:0]      resize_ff;
   logic [CNT_W-1:0] vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         resize_ff <= RESIZE_RESET;
         vcount_ff <= CNT_W'(MIN_VERTS);
      end else if (csr_wr) begin
         if (csr_index == REG_RESIZE) begin
            resize_ff <= csr_data;
         end else if (csr_index == REG_VCOUNT) begin
            vcount_ff <= csr_data[CNT_W-1:0];
         end
      end
   end

   // request beat fields
   logic signed [31:0] hdr_scale  [3];
   logic signed [31:0] hdr_offset [3];
   logic        [7:0]  hdr_byte   [3];
   logic        [7:0]  hdr_normal;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hdr_scale[i]  = req_tdata[32*i +: 32];
         hdr_offset[i] = req_tdata[96 + 32*i +: 32];
         hdr_byte[i]   = req_tdata[192 + 8*i +: 8];
      end
      hdr_normal = req_tdata[216 +: 8];
   end

   // frame transform, reset to zero
   logic signed [31:0] gain_ff   [3];
   logic signed [31:0] offset_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            gain_ff[i]   <= '0;
            offset_ff[i] <= '0;
         end
      end else if (cmd.load_hdr) begin
         for (int i = 0; i < 3; i++) begin
            gain_ff[i]   <= hdr_scale[i];
            offset_ff[i] <= hdr_offset[i];
         end
      end
   end

   // vertex operands
   logic [7:0] bytes_ff [3];
   logic [7:0] normal_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_vtx) begin
         for (int i = 0; i < 3; i++) begin
            bytes_ff[i] <= hdr_byte[i];
         end
         normal_ff <= hdr_normal;
      end
   end

   // per-axis arithmetic chain
   logic        [AXIS_W-1:0] fa;
   logic        [7:0]        byte_sel;
   logic signed [31:0]       gain_sel;
   logic signed [31:0]       off_sel;
   logic signed [31:0]       pos_sel;

   logic        [39:0] a_ff;
   logic signed [56:0] ph_ff;
   logic signed [48:0] pl_ff;
   logic signed [41:0] c_ff;
   logic signed [63:0] m_ff;
   logic signed [31:0] pos_ff [3];
   logic        [62:0] sq_ff;
   logic        [63:0] acc_ff;

   logic signed [57:0] sum_full;
   logic signed [41:0] c_clamped;
   logic signed [63:0] rnd_full;
   logic signed [63:0] rnd_q;
   logic signed [31:0] rnd_sat;
   logic signed [63:0] sq_full;
   logic        [62:0] rad_sat;

   always_comb begin
      fa       = file_axis(cmd.axis);
      byte_sel = bytes_ff[fa];
      gain_sel = gain_ff[fa];
      off_sel  = offset_ff[fa];
      pos_sel  = pos_ff[cmd.axis];

      // floor(a*s/2^16) split as upper part times s plus floored lower part
      sum_full = ph_ff + (pl_ff >>> 16) + off_sel;
      if (sum_full > C_LIM) begin
         c_clamped = C_LIM[41:0];
      end else if (sum_full < -C_LIM) begin
         c_clamped = 42'(-C_LIM);
      end else begin
         c_clamped = sum_full[41:0];
      end

      // round half up after optional negation
      if (cmd.axis != AXIS_POS) begin
         rnd_full = RND_HALF - m_ff;
      end else begin
         rnd_full = m_ff + RND_HALF;
      end
      rnd_q = rnd_full >>> 24;
      if (rnd_q > I32_MAX) begin
         rnd_sat = POS_MAX;
      end else if (rnd_q < I32_MIN) begin
         rnd_sat = POS_MIN;
      end else begin
         rnd_sat = rnd_q[31:0];
      end

      sq_full = pos_sel * pos_sel;
      rad_sat = acc_ff[63] ? RAD_MAX : acc_ff[62:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vtx) begin
         acc_ff <= '0;
      end
      unique case (cmd.step)
         STEP_MA:  a_ff  <= byte_sel * resize_ff;
         STEP_MH:  ph_ff <= $signed({1'b0, a_ff[39:16]}) * gain_sel;
         STEP_ML:  pl_ff <= $signed({1'b0, a_ff[15:0]}) * gain_sel;
         STEP_SUM: c_ff  <= c_clamped;
         STEP_MK:  m_ff  <= c_ff * $signed({1'b0, K_007});
         STEP_RND: pos_ff[cmd.axis] <= rnd_sat;
         STEP_SQ:  sq_ff <= sq_full[62:0];
         STEP_ACC: acc_ff <= acc_ff + {1'b0, sq_ff};
         default: ;
      endcase
   end

   // frame length check
   logic [31:0] vc32;
   logic [31:0] count_lim;
   logic [31:0] next_idx;
   logic        at_frame_end;
   logic [IDX_W-1:0] index_ff;

   always_comb begin
      vc32 = 32'(vcount_ff);
      if (vc32 < 32'(MIN_VERTS)) begin
         count_lim = 32'(MIN_VERTS);
      end else if (vc32 > 32'(MAX_VERTS)) begin
         count_lim = 32'(MAX_VERTS);
      end else begin
         count_lim = vc32;
      end
      next_idx     = 32'(index_ff) + 32'd1;
      at_frame_end = next_idx >= count_lim;
   end

   // bounds
   logic signed [31:0] frame_min_ff [3];
   logic signed [31:0] frame_max_ff [3];
   logic signed [31:0] model_min_ff [3];
   logic signed [31:0] model_max_ff [3];
   logic        [62:0] frame_rad_ff;
   logic        [62:0] model_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            frame_min_ff[i] <= POS_MAX;
            frame_max_ff[i] <= POS_MIN;
            model_min_ff[i] <= POS_MAX;
            model_max_ff[i] <= POS_MIN;
         end
         frame_rad_ff <= '0;
         model_rad_ff <= '0;
         index_ff     <= '0;
      end else begin
         priority if (cmd.load_hdr) begin
            for (int i = 0; i < 3; i++) begin
               frame_min_ff[i] <= POS_MAX;
               frame_max_ff[i] <= POS_MIN;
            end
            frame_rad_ff <= '0;
            index_ff     <= '0;
         end else if (cmd.emit_vtx) begin
            for (int i = 0; i < 3; i++) begin
               if (pos_ff[i] < frame_min_ff[i]) frame_min_ff[i] <= pos_ff[i];
               if (pos_ff[i] > frame_max_ff[i]) frame_max_ff[i] <= pos_ff[i];
               if (pos_ff[i] < model_min_ff[i]) model_min_ff[i] <= pos_ff[i];
               if (pos_ff[i] > model_max_ff[i]) model_max_ff[i] <= pos_ff[i];
            end
            if (rad_sat > frame_rad_ff) frame_rad_ff <= rad_sat;
            if (rad_sat > model_rad_ff) model_rad_ff <= rad_sat;
            index_ff <= status.frame_end ? '0 : index_ff + 1'b1;
         end else if (cmd.emit_frame) begin
            for (int i = 0; i < 3; i++) begin
               frame_min_ff[i] <= POS_MAX;
               frame_max_ff[i] <= POS_MIN;
            end
            frame_rad_ff <= '0;
         end else if (cmd.emit_model) begin
            for (int i = 0; i < 3; i++) begin
               frame_min_ff[i] <= POS_MAX;
               frame_max_ff[i] <= POS_MIN;
               model_min_ff[i] <= POS_MAX;
               model_max_ff[i] <= POS_MIN;
            end
            frame_rad_ff <= '0;
            model_rad_ff <= '0;
            index_ff     <= '0;
         end else begin
         end
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic        [1:0]  out_kind_ff;
   logic signed [31:0] out_min_ff [3];
   logic signed [31:0] out_max_ff [3];
   logic        [62:0] out_rad_ff;
   logic        [7:0]  out_normal_ff;
   logic               out_bad_ff;
   logic               out_last_ff;

   assign status = '{out_free: !rsp_valid_ff || rsp_tready, frame_end: at_frame_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_vtx || cmd.emit_frame || cmd.emit_model) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.emit_vtx) begin
         out_kind_ff <= KIND_VERTEX;
         for (int i = 0; i < 3; i++) begin
            out_min_ff[i] <= pos_ff[i];
            out_max_ff[i] <= '0;
         end
         out_rad_ff    <= rad_sat;
         out_normal_ff <= normal_ff;
         out_bad_ff    <= normal_ff >= 8'(NORMAL_COUNT);
         out_last_ff   <= !status.frame_end;
      end else if (cmd.emit_frame) begin
         out_kind_ff <= KIND_FRAME;
         for (int i = 0; i < 3; i++) begin
            out_min_ff[i] <= frame_min_ff[i];
            out_max_ff[i] <= frame_max_ff[i];
         end
         out_rad_ff    <= frame_rad_ff;
         out_normal_ff <= '0;
         out_bad_ff    <= 1'b0;
         out_last_ff   <= 1'b1;
      end else if (cmd.emit_model) begin
         out_kind_ff <= KIND_MODEL;
         for (int i = 0; i < 3; i++) begin
            out_min_ff[i] <= model_min_ff[i];
            out_max_ff[i] <= model_max_ff[i];
         end
         out_rad_ff    <= model_rad_ff;
         out_normal_ff <= '0;
         out_bad_ff    <= 1'b0;
         out_last_ff   <= 1'b1;
      end else begin
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_bad_ff, out_normal_ff, out_rad_ff,
                        out_max_ff[2], out_max_ff[1], out_max_ff[0],
                        out_min_ff[2], out_min_ff[1], out_min_ff[0]};

endmodule

>>> rtl/qvdb_ctrl.sv
// Sequencer of the vertex decoder: takes request beats and steps the
// datapath through the per-axis chain and the result beats. Uses qvdb_pkg.
module qvdb_ctrl import qvdb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [1:0]      req_tuser,
   input  qvdb_status_type status,
   output qvdb_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STEP = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_FB   = 3'd3;
   localparam logic [2:0] S_MB   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              accept;

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.step = STEP_NONE;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  OPC_HEADER: cmd.load_hdr = 1'b1;
                  OPC_VERTEX: begin
                     cmd.load_vtx = 1'b1;
                     state_in     = S_STEP;
                     step_in      = STEP_MA;
                     axis_in      = AXIS_FIRST;
                  end
                  OPC_FINISH: state_in = S_MB;
                  default: ;  // drop
               endcase
            end
         end
         S_STEP: begin
            cmd.step = step_ff;
            if (step_ff == STEP_ACC) begin
               step_in = STEP_MA;
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_UPD;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_UPD: begin
            // hold until the result register frees up
            if (status.out_free) begin
               cmd.emit_vtx = 1'b1;
               state_in     = status.frame_end ? S_FB : S_IDLE;
            end
         end
         S_FB: begin
            if (status.out_free) begin
               cmd.emit_frame = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_MB: begin
            if (status.out_free) begin
               cmd.emit_model = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_MA;
         axis_ff  <= AXIS_FIRST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_frame_follows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && status.out_free && status.frame_end) |=> (state_ff == S_FB))
      else $error("frame bounds beat not scheduled after last vertex");

   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_vtx || cmd.emit_frame || cmd.emit_model) |-> status.out_free)
      else $error("result loaded while result register busy");

   a_axis_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (axis_ff <= AXIS_LAST))
      else $error("axis counter out of range");

   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_hdr, cmd.load_vtx, cmd.emit_vtx, cmd.emit_frame, cmd.emit_model}))
      else $error("conflicting datapath commands");
`endif

endmodule
